@@ rtl/jsu_pkg.sv @@
// jsu_pkg: shared widths and the decoded-operation record passed from the
// front end to the back end of the JSON string unescaper.
// No dependencies.
package jsu_pkg;

    localparam int LIMIT_W = 11;  // out_limit field
    localparam int LEN_W   = 10;  // out_length field
    localparam int OP_MAX  = 4;   // bytes one input beat can produce

    // One decoded input beat: up to four candidate bytes in order.
    // atomic: all bytes fit or none are written (one UTF-8 sequence).
    typedef struct packed {
        logic [OP_MAX-1:0][7:0] bytes;
        logic [2:0]             n;
        logic                   atomic;
        logic                   first;
        logic                   last;
        logic [LIMIT_W-1:0]     limit;
    } t_op;

endpackage

@@ rtl/jsu_ifs.sv @@
// jsu_in_if / jsu_out_if: valid/ready channels of the JSON string unescaper.
// No dependencies.
interface jsu_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  in_byte;
    logic        first;
    logic        last;
    logic [10:0] out_limit;

    modport source (output valid, in_byte, first, last, out_limit, input ready);
    modport sink   (input valid, in_byte, first, last, out_limit, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_string;
    logic [9:0] out_length;

    modport source (output valid, out_byte, has_byte, end_of_string, out_length,
                    input ready);
    modport sink   (input valid, out_byte, has_byte, end_of_string, out_length,
                    output ready);
endinterface

@@ rtl/jsu_front.sv @@
// jsu_front: escape decoder. Classifies each input beat into a t_op.
// Depends on jsu_pkg and jsu_in_if.
module jsu_front
    import jsu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    jsu_in_if.sink   i_in,
    input  logic     i_can_push,
    output logic     o_push,
    output t_op      o_op
);

    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_U   = 8'h75;
    localparam logic [7:0] CH_N   = 8'h6E;
    localparam logic [7:0] CH_R   = 8'h72;
    localparam logic [7:0] CH_T   = 8'h74;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;

    typedef enum logic [2:0] {
        M_NORMAL = 3'b001,
        M_ESC    = 3'b010,
        M_HEX    = 3'b100
    } t_mode;

    typedef struct packed {
        logic [OP_MAX-1:0][7:0] bytes;
        logic [2:0]             n;
    } t_emit;

    function automatic logic [7:0] esc_map(input logic [7:0] ch);
        logic [7:0] r;
        r = ch;
        if (ch == CH_N) r = CH_LF;
        else if (ch == CH_R) r = CH_CR;
        else if (ch == CH_T) r = CH_TAB;
        return r;
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_val(input logic [7:0] ch);
        logic [7:0] d;
        logic [4:0] r;
        r = '0;
        d = '0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            d = ch - 8'h30;
            r = {1'b1, d[3:0]};
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            d = ch - 8'h57;
            r = {1'b1, d[3:0]};
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            d = ch - 8'h37;
            r = {1'b1, d[3:0]};
        end
        return r;
    endfunction

    function automatic t_emit utf8_enc(input logic [15:0] cp);
        t_emit r;
        r = '0;
        if (cp < 16'h0080) begin
            r.bytes[0] = cp[7:0];
            r.n        = 3'd1;
        end else if (cp < 16'h0800) begin
            r.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
            r.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
            r.n        = 3'd2;
        end else begin
            r.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
            r.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
            r.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
            r.n        = 3'd3;
        end
        return r;
    endfunction

    // Short \u at end of string: 'u', then replay the held chars from normal
    // mode, the last one counting as end of string.
    function automatic t_emit replay(input logic [2:0][7:0] buf_c,
                                     input logic [1:0] nch);
        t_emit      r;
        t_mode      m;
        logic       fin;
        logic [7:0] ch;
        r          = '0;
        r.bytes[0] = CH_U;
        r.n        = 3'd1;
        m          = M_NORMAL;
        for (int k = 0; k < 3; k++) begin
            ch  = buf_c[k];
            fin = (k == int'(nch) - 1);
            if (k < int'(nch)) begin
                unique case (m)
                    M_NORMAL: begin
                        if (ch == CH_BSL && !fin) begin
                            m = M_ESC;
                        end else begin
                            r.bytes[r.n[1:0]] = ch;
                            r.n = r.n + 3'd1;
                        end
                    end
                    M_ESC: begin
                        m = M_NORMAL;
                        if (ch == CH_U && !fin) begin
                            m = M_HEX;
                        end else begin
                            r.bytes[r.n[1:0]] = esc_map(ch);
                            r.n = r.n + 3'd1;
                        end
                    end
                    M_HEX: begin
                        // only the final char can land here
                        r.bytes[r.n[1:0]] = CH_U;
                        r.n = r.n + 3'd1;
                        r.bytes[r.n[1:0]] = ch;
                        r.n = r.n + 3'd1;
                        m = M_NORMAL;
                    end
                    default: m = M_NORMAL;
                endcase
            end
        end
        return r;
    endfunction

    t_mode       r_mode, n_mode, e_mode;
    logic [1:0]  r_hcnt, n_hcnt, e_hcnt;
    logic [15:0] r_acc, n_acc, e_acc, acc_sh;
    logic [7:0]  r_held [3];
    logic        held_we;
    logic [4:0]  hv;
    logic [7:0]  ch;
    logic        fin;
    t_emit       em;
    logic [2:0][7:0] rbuf;

    assign i_in.ready = i_can_push;
    assign o_push     = i_in.valid && i_can_push;

    always_comb begin
        ch     = i_in.in_byte;
        fin    = i_in.last;
        e_mode = i_in.first ? M_NORMAL : r_mode;
        e_hcnt = i_in.first ? 2'd0 : r_hcnt;
        e_acc  = i_in.first ? 16'd0 : r_acc;
        hv     = hex_val(ch);
        acc_sh = hv[4] ? {e_acc[11:0], hv[3:0]} : e_acc;
        for (int k = 0; k < 3; k++) begin
            rbuf[k] = (k < int'(e_hcnt)) ? r_held[k] : ch;
        end
        n_mode  = e_mode;
        n_hcnt  = e_hcnt;
        n_acc   = e_acc;
        held_we = 1'b0;
        em      = '0;
        o_op    = '0;
        unique case (e_mode)
            M_NORMAL: begin
                if (ch == CH_BSL && !fin) begin
                    n_mode = M_ESC;
                end else begin
                    em.bytes[0] = ch;
                    em.n        = 3'd1;
                end
            end
            M_ESC: begin
                n_mode = M_NORMAL;
                if (ch == CH_U && !fin) begin
                    n_mode = M_HEX;
                    n_hcnt = 2'd0;
                    n_acc  = 16'd0;
                end else begin
                    em.bytes[0] = esc_map(ch);
                    em.n        = 3'd1;
                end
            end
            M_HEX: begin
                if (e_hcnt == 2'd3) begin
                    em          = utf8_enc(acc_sh);
                    o_op.atomic = 1'b1;
                    n_mode      = M_NORMAL;
                    n_hcnt      = 2'd0;
                    n_acc       = 16'd0;
                end else if (fin) begin
                    em     = replay(rbuf, e_hcnt + 2'd1);
                    n_mode = M_NORMAL;
                    n_hcnt = 2'd0;
                    n_acc  = 16'd0;
                end else begin
                    held_we = 1'b1;
                    n_hcnt  = e_hcnt + 2'd1;
                    n_acc   = acc_sh;
                end
            end
            default: n_mode = M_NORMAL;
        endcase
        if (fin) begin
            n_mode = M_NORMAL;
            n_hcnt = 2'd0;
            n_acc  = 16'd0;
        end
        o_op.bytes = em.bytes;
        o_op.n     = em.n;
        o_op.first = i_in.first;
        o_op.last  = fin;
        o_op.limit = i_in.out_limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_NORMAL;
            r_hcnt <= 2'd0;
            r_acc  <= 16'd0;
        end else if (o_push) begin
            r_mode <= n_mode;
            r_hcnt <= n_hcnt;
            r_acc  <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push && held_we) begin
            r_held[e_hcnt] <= ch;
        end
    end

endmodule

@@ rtl/jsu_fifo.sv @@
// jsu_fifo: four-entry queue of decoded operations between front and back.
// Depends on jsu_pkg.
module jsu_fifo
    import jsu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_data,
    output logic o_can_push,
    input  logic i_pop,
    output logic o_head_valid,
    output t_op  o_head
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    t_op           r_slot [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;

    assign o_can_push   = r_cnt != (PW+1)'(DEPTH);
    assign o_head_valid = r_cnt != '0;
    assign o_head       = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + PW'(1);
            if (i_pop)  r_rp <= r_rp + PW'(1);
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

endmodule

@@ rtl/jsu_back.sv @@
// jsu_back: applies the output limit to queued operations and emits one
// result beat per cycle, unless the output stalls, via an output register.
// Depends on jsu_pkg and jsu_out_if.
module jsu_back
    import jsu_pkg::*;
#(
    parameter int unsigned MAX_OUT = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_op       i_head,
    input  logic      i_head_valid,
    output logic      o_pop,
    jsu_out_if.source o_out
);

    localparam int unsigned LIM_TOP = 2**LIMIT_W - 1;
    localparam int unsigned CAP_MAX = (MAX_OUT < LIM_TOP) ? MAX_OUT : LIM_TOP;
    localparam int          CNT_W   = $clog2(CAP_MAX);
    localparam int          CW3     = CNT_W + 3;

    logic [CNT_W-1:0] r_cnt, r_cap;
    logic             r_full;
    logic [1:0]       r_idx;

    logic             r_ovalid, r_ohas, r_oeos;
    logic [7:0]       r_obyte;
    logic [LEN_W-1:0] r_olen;

    logic [CNT_W-1:0] cap_calc, e_cnt, e_cap, cnt_inc, n_len_src;
    logic             apply_first, e_full, full_now, fits, fail, emit;
    logic             last_b, done, adv, step;
    logic [CNT_W+LEN_W-1:0] len_wide;

    always_comb begin
        if (i_head.limit == '0) begin
            cap_calc = '0;
        end else if (32'(i_head.limit) > MAX_OUT) begin
            cap_calc = CNT_W'(MAX_OUT - 1);
        end else begin
            cap_calc = CNT_W'(i_head.limit - LIMIT_W'(1));
        end
        apply_first = i_head.first && (r_idx == 2'd0);
        e_cnt    = apply_first ? '0 : r_cnt;
        e_cap    = apply_first ? cap_calc : r_cap;
        e_full   = apply_first ? 1'b0 : r_full;
        full_now = e_full || (e_cnt >= e_cap);
        fits     = (CW3'(e_cnt) + CW3'(i_head.n)) <= CW3'(e_cap);
        fail     = i_head.atomic && (r_idx == 2'd0) && !full_now && !fits;
        emit     = !full_now && !fail && (i_head.n != 3'd0);
        cnt_inc  = e_cnt + CNT_W'(1);
        last_b   = ({1'b0, r_idx} == (i_head.n - 3'd1));
        done     = emit ? (last_b || (cnt_inc == e_cap)) : 1'b1;
        adv      = !r_ovalid || o_out.ready;
        step     = i_head_valid && adv;
        n_len_src = emit ? cnt_inc : e_cnt;
        len_wide = {{LEN_W{1'b0}}, n_len_src};
    end

    assign o_pop = step && done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_cap    <= '0;
            r_full   <= 1'b0;
            r_idx    <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (step) begin
                if (apply_first) r_cap <= cap_calc;
                // end of string clears count and full flag, capacity is kept
                r_cnt  <= (done && i_head.last) ? '0 : n_len_src;
                r_full <= (done && i_head.last) ? 1'b0 : (e_full || fail);
                r_idx  <= done ? 2'd0 : r_idx + 2'd1;
            end
            if (adv) begin
                r_ovalid <= step && (emit || i_head.last);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_obyte <= emit ? i_head.bytes[r_idx] : 8'h00;
            r_ohas  <= emit;
            r_oeos  <= i_head.last && done;
            r_olen  <= len_wide[LEN_W-1:0];
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.out_byte      = r_obyte;
    assign o_out.has_byte      = r_ohas;
    assign o_out.end_of_string = r_oeos;
    assign o_out.out_length    = r_olen;

`ifndef SYNTH
    a_cnt_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= r_cap)
        else $error("written count passed capacity");

    a_bare_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !r_ohas |-> r_oeos)
        else $error("bare result without end_of_string");

    a_mid_item_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 2'd0 |-> i_head_valid)
        else $error("mid-item with empty queue");
`endif

endmodule

@@ rtl/json_string_unescape_utf8.sv @@
// Path: an accepted beat passes through the operation queue, then the back
// end's output register. Throughput: one input beat per cycle while each
// beat yields at most one result and the output is not stalled; a beat
// yielding several bytes holds the back end while it emits them, and the
// four-entry operation queue absorbs the burst. The back end's byte emitter
// (one result per cycle) sets the sustained rate.
// Reset (synchronous, active low): decoder normal, queue empty, count zero,
// capacity zero (limit of one) until a first beat loads a new limit.
module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int unsigned MAX_OUT = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_out_if.source o_out
);

    // Front end: escape / \uXXXX decoder. Tracks escape mode, hex digit count,
    // accumulated code point and held chars; turns each beat into a list of
    // up to four candidate bytes (atomic when it is one UTF-8 sequence).
    // The decoder ignores the output limit: once full, nothing more is written
    // anyway, so mode tracking past that point is harmless.
    t_op  op, head;
    logic push, can_push, pop, head_valid;

    jsu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_can_push (can_push),
        .o_push     (push),
        .o_op       (op)
    );

    // Decoupling queue: front and back stall independently.
    jsu_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_data       (op),
        .o_can_push   (can_push),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // Back end: written count vs. limit-1 capacity, all-or-nothing UTF-8,
    // end marker for a final beat that writes nothing, registered output.
    jsu_back #(
        .MAX_OUT (MAX_OUT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

@@ tb/json_string_unescape_utf8_test.sv @@
// Self-checking testbench for json_string_unescape_utf8: string bodies go in one byte per
// beat, and each decoded byte or end marker is checked against a cycle-free predictor.
// Depends on rtl/jsu_pkg.sv, rtl/jsu_ifs.sv and rtl/json_string_unescape_utf8.sv.
module json_string_unescape_utf8_test
    import jsu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_OUT      = 1024;
    localparam int          RANDOM_BEATS = 200;
    localparam int          END_CYCLES   = 16;   // leave plenty of slack for the last results

    // Characters with a meaning to the decoder
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    typedef enum logic [1:0] {
        DEC_NORMAL,
        DEC_ESC,
        DEC_HEX
    } dec_mode_t;

    // One input beat
    typedef struct packed {
        logic [7:0]         data;
        logic               first;
        logic               last;
        logic [LIMIT_W-1:0] limit;
    } text_beat_t;

    // One output beat
    typedef struct packed {
        logic [7:0]       data;
        logic             has;
        logic             eos;
        logic [LEN_W-1:0] len;
    } decoded_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    jsu_in_if  in_ch ();
    jsu_out_if out_ch ();

    json_string_unescape_utf8 #(
        .MAX_OUT (MAX_OUT)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Queues and counters
    // ------------------------------------------------------------------
    text_beat_t text_beats_q[$];   // beats waiting for the driver
    decoded_t   decoded_q[$];      // predicted output beats, oldest first
    logic [7:0] text_q[$];         // string body under construction

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors        = 0;
    int beats_queued  = 0;
    int beats_in      = 0;
    int results_seen  = 0;
    int markers_seen  = 0;
    int strings_sent  = 0;

    // ------------------------------------------------------------------
    // Decoder predictor state
    // ------------------------------------------------------------------
    dec_mode_t   dec_mode  = DEC_NORMAL;
    int unsigned hex_seen  = 0;          // characters taken after \u so far
    logic [15:0] code_acc  = '0;
    logic [7:0]  held_ch [3];            // characters after \u, replayed if the string ends early
    int unsigned out_count = 0;
    int unsigned limit_r   = 1;
    bit          out_full  = 1'b0;
    decoded_t    beat_out[$];            // bytes produced by the beat being decoded

    function automatic void log_error(string msg);
        errors++;
        if (errors <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function automatic void reset_string();
        dec_mode  = DEC_NORMAL;
        hex_seen  = 0;
        code_acc  = '0;
        out_count = 0;
        out_full  = 1'b0;
    endfunction

    // Capacity is limit-1; once reached the string stays full until it ends.
    function automatic bit at_capacity();
        if (out_count >= limit_r - 1)
            out_full = 1'b1;
        return out_full;
    endfunction

    function automatic void emit(logic [7:0] b);
        decoded_t r;
        if (at_capacity() || beat_out.size() >= OP_MAX)
            return;
        out_count++;
        r = '{data: b, has: 1'b1, eos: 1'b0, len: LEN_W'(out_count)};
        beat_out.push_back(r);
    endfunction

    // A UTF-8 sequence is written whole or not at all; a misfit ends the string's output.
    function automatic void emit_code(logic [15:0] cp);
        int unsigned n;
        n = (cp < 16'h0080) ? 1 : (cp < 16'h0800) ? 2 : 3;
        if (at_capacity())
            return;
        if (out_count + n > limit_r - 1) begin
            out_full = 1'b1;
            return;
        end
        case (n)
            1: begin
                emit(cp[7:0]);
            end
            2: begin
                emit({3'b110, cp[10:6]});
                emit({2'b10, cp[5:0]});
            end
            default: begin
                emit({4'b1110, cp[15:12]});
                emit({2'b10, cp[11:6]});
                emit({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    function automatic int hex_val(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - 48;
        if (c >= "a" && c <= "f") return int'(c) - 87;
        if (c >= "A" && c <= "F") return int'(c) - 55;
        return -1;
    endfunction

    // Decode one accepted beat and append its output beats to decoded_q.
    // A string that ends inside \u puts its held characters back on the work
    // list; only the very last one of them counts as the end of the string.
    function automatic void decode_beat(text_beat_t b);
        logic [7:0]  work[$];
        logic [7:0]  c;
        bit          fin;
        int          v;
        int unsigned lim;
        decoded_t    tail;
        if (b.first) begin
            reset_string();
            lim = b.limit;
            if (lim < 1) lim = 1;
            if (lim > MAX_OUT) lim = MAX_OUT;
            limit_r = lim;
        end
        beat_out.delete();
        work.push_back(b.data);
        while (work.size() > 0) begin
            c   = work.pop_front();
            fin = b.last && (work.size() == 0);
            v   = hex_val(c);
            case (dec_mode)
                DEC_ESC: begin
                    dec_mode = DEC_NORMAL;
                    if (c == CH_U && !fin) begin
                        dec_mode = DEC_HEX;
                        hex_seen = 0;
                        code_acc = '0;
                    end else if (c == CH_N) begin
                        emit(CH_LF);
                    end else if (c == CH_R) begin
                        emit(CH_CR);
                    end else if (c == CH_T) begin
                        emit(CH_TAB);
                    end else begin
                        emit(c);    // \" \\ \/ and unknown escapes drop the backslash
                    end
                end
                DEC_HEX: begin
                    if (hex_seen >= 3) begin
                        if (v >= 0)
                            code_acc = {code_acc[11:0], 4'(v)};
                        dec_mode = DEC_NORMAL;
                        hex_seen = 0;
                        emit_code(code_acc);
                        code_acc = '0;
                    end else if (fin) begin
                        // string ended early: literal 'u', then replay what was held
                        for (int k = 0; k < hex_seen; k++)
                            work.push_back(held_ch[k]);
                        work.push_back(c);
                        dec_mode = DEC_NORMAL;
                        hex_seen = 0;
                        code_acc = '0;
                        emit(CH_U);
                    end else begin
                        held_ch[hex_seen] = c;
                        hex_seen++;
                        if (v >= 0)
                            code_acc = {code_acc[11:0], 4'(v)};
                    end
                end
                default: begin
                    dec_mode = DEC_NORMAL;
                    if (!at_capacity()) begin
                        if (c == CH_BSLASH && !fin)
                            dec_mode = DEC_ESC;
                        else
                            emit(c);    // includes a lone backslash at the end
                    end
                end
            endcase
        end
        if (b.last) begin
            if (beat_out.size() > 0) begin
                tail = beat_out.pop_back();
                tail.eos = 1'b1;
                beat_out.push_back(tail);
            end else begin
                tail = '{data: 8'h00, has: 1'b0, eos: 1'b1, len: LEN_W'(out_count)};
                beat_out.push_back(tail);
            end
            reset_string();     // limit is kept for a string that starts without first
        end
        foreach (beat_out[i])
            decoded_q.push_back(beat_out[i]);
    endfunction

    // ------------------------------------------------------------------
    // Driver: next beat goes out once the current one is taken
    // ------------------------------------------------------------------
    text_beat_t next_beat;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (text_beats_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                next_beat          = text_beats_q.pop_front();
                in_ch.valid       <= 1'b1;
                in_ch.in_byte     <= next_beat.data;
                in_ch.first       <= next_beat.first;
                in_ch.last        <= next_beat.last;
                in_ch.out_limit   <= next_beat.limit;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on every accepted input beat, checks every output beat
    // ------------------------------------------------------------------
    text_beat_t seen_beat;
    decoded_t   got;
    decoded_t   want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            // input side first, so a same-edge result could never miss its prediction
            if (in_ch.valid && in_ch.ready) begin
                seen_beat = '{data: in_ch.in_byte, first: in_ch.first, last: in_ch.last,
                              limit: in_ch.out_limit};
                decode_beat(seen_beat);
                beats_in++;
            end
            if (out_ch.valid && out_ch.ready) begin
                got = '{data: out_ch.out_byte, has: out_ch.has_byte,
                        eos: out_ch.end_of_string, len: out_ch.out_length};
                results_seen++;
                if (!got.has)
                    markers_seen++;
                if (decoded_q.size() == 0) begin
                    log_error($sformatf("unexpected beat: byte %02h has %0b end %0b len %0d",
                                        got.data, got.has, got.eos, got.len));
                end else begin
                    want = decoded_q.pop_front();
                    if (got.data !== want.data || got.has !== want.has ||
                        got.eos !== want.eos || got.len !== want.len)
                        log_error($sformatf({"beat %0d: expected byte %02h has %0b end %0b ",
                                             "len %0d, got byte %02h has %0b end %0b len %0d"},
                                            results_seen, want.data, want.has, want.eos,
                                            want.len, got.data, got.has, got.eos, got.len));
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    // Turn text_q into beats. Limit bits on non-first beats are don't-care, so randomize them.
    task automatic send_text(logic [LIMIT_W-1:0] lim, bit with_first, bit with_last);
        text_beat_t b;
        for (int i = 0; i < text_q.size(); i++) begin
            b.data  = text_q[i];
            b.first = with_first && (i == 0);
            b.last  = with_last && (i == text_q.size() - 1);
            b.limit = (i == 0) ? lim : LIMIT_W'($urandom_range(2047));
            text_beats_q.push_back(b);
            beats_queued++;
        end
        text_q.delete();
        strings_sent++;
    endtask

    function automatic logic [7:0] hex_digit(logic [3:0] n, bit upper);
        if (n < 10)
            return 8'h30 + 8'(n);
        return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    // \uXXXX spread over the 1-, 2- and 3-byte UTF-8 ranges; now and then a
    // digit is replaced by a non-hex letter, which the decoder skips
    task automatic add_unicode();
        logic [15:0] cp;
        int          sel;
        sel = $urandom_range(2);
        if (sel == 0)      cp = 16'($urandom_range(16'h007F));
        else if (sel == 1) cp = 16'($urandom_range(16'h07FF, 16'h0080));
        else               cp = 16'($urandom_range(16'hFFFF, 16'h0800));
        text_q.push_back(CH_BSLASH);
        text_q.push_back(CH_U);
        for (int k = 3; k >= 0; k--) begin
            if ($urandom_range(99) < 8)
                text_q.push_back(8'h67 + 8'($urandom_range(19)));   // g..z
            else
                text_q.push_back(hex_digit(cp[4*k +: 4], 1'($urandom_range(1))));
        end
    endtask

    task automatic add_token();
        int         kind;
        logic [7:0] c;
        string      simple;
        simple = "nrt\"\\/";
        kind   = $urandom_range(99);
        if (kind < 35) begin
            do c = 8'($urandom_range(126, 32)); while (c == CH_BSLASH);
            text_q.push_back(c);
        end else if (kind < 45) begin
            text_q.push_back(8'($urandom_range(255)));
        end else if (kind < 65) begin
            text_q.push_back(CH_BSLASH);
            text_q.push_back(simple[$urandom_range(5)]);
        end else if (kind < 72) begin
            text_q.push_back(CH_BSLASH);
            text_q.push_back(8'($urandom_range(255)));
        end else begin
            add_unicode();
        end
    endtask

    // One random string: a few tokens, sometimes an awkward ending, mostly
    // terminated and mostly opened with first.
    task automatic random_string();
        logic [LIMIT_W-1:0] lim;
        int                 r;
        int                 ntok;
        int                 nheld;
        r = $urandom_range(99);
        if (r < 55)      lim = LIMIT_W'($urandom_range(12, 1));
        else if (r < 80) lim = LIMIT_W'($urandom_range(64, 13));
        else if (r < 88) lim = LIMIT_W'($urandom_range(1));
        else if (r < 94) lim = LIMIT_W'(MAX_OUT);
        else             lim = LIMIT_W'($urandom_range(2047));
        ntok = $urandom_range(4, 1);
        repeat (ntok) add_token();
        r = $urandom_range(99);
        if (r < 14) begin
            // \u cut short; the characters after it may themselves start escapes
            text_q.push_back(CH_BSLASH);
            text_q.push_back(CH_U);
            nheld = $urandom_range(3);
            repeat (nheld) begin
                r = $urandom_range(99);
                if (r < 40)      text_q.push_back(hex_digit(4'($urandom_range(15)), 1'b0));
                else if (r < 55) text_q.push_back(CH_BSLASH);
                else if (r < 70) text_q.push_back(CH_U);
                else             text_q.push_back(8'($urandom_range(255)));
            end
        end else if (r < 20) begin
            text_q.push_back(CH_BSLASH);
        end
        send_text(lim, $urandom_range(99) < 85, $urandom_range(99) < 88);
    endtask

    // Hold off until every queued beat is taken and every prediction is matched.
    task automatic wait_drained();
        while (text_beats_q.size() != 0 || in_ch.valid || decoded_q.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    int base_beats;

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.in_byte   = 8'h00;
        in_ch.first     = 1'b0;
        in_ch.last      = 1'b0;
        in_ch.out_limit = '0;
        out_ch.ready    = 1'b0;
        i_rst_n         = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 87;

        // Directed: all named escapes, limit above the maximum
        add_text("\\n\\r\\t\\\"\\\\\\/");
        send_text(11'd2047, 1'b1, 1'b1);
        // limit 0: no room at all, top byte value, bare end marker
        text_q.push_back(8'hFF);
        send_text(11'd0, 1'b1, 1'b1);
        // 3-byte sequence into a 2-byte buffer: nothing written, marker at the end
        add_text("\\u20AC");
        send_text(11'd3, 1'b1, 1'b1);
        // next string without first keeps the limit; \u cut short after one digit
        add_text("\\u4");
        send_text(11'd0, 1'b0, 1'b1);
        // lone backslash as the final byte
        add_text("\\");
        send_text(11'd1024, 1'b1, 1'b1);
        // escaped u as the final byte
        add_text("\\u");
        send_text(11'd16, 1'b1, 1'b1);
        // zero byte, unknown escape, then \u left open and cut off by a new first
        text_q.push_back(8'h00);
        add_text("\\q\\u1");
        send_text(11'd16, 1'b1, 1'b0);
        add_text("A");
        send_text(11'd16, 1'b1, 1'b1);
        wait_drained();     // sender held off until the block has emptied

        // Random part in three idle profiles
        base_beats = beats_queued;
        for (int p = 0; p < 3; p++) begin
            if (p == 1) begin
                send_idle_pct = 87;
                recv_idle_pct = 28;
            end else if (p == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            while (beats_queued < base_beats + RANDOM_BEATS * (p + 1) / 3)
                random_string();
            wait_drained();
        end

        repeat (END_CYCLES) @(posedge i_clk);
        if (decoded_q.size() != 0)
            log_error($sformatf("%0d predicted beats never came out", decoded_q.size()));

        $display("Covered %0d strings in %0d input beats; %0d output beats checked, %0d bare",
                 strings_sent, beats_in, results_seen, markers_seen);
        $display("end markers among them; %0d mismatches in total.", errors);
        if (errors == 0)
            $display("PASS json_string_unescape_utf8");
        else
            $display("FAIL json_string_unescape_utf8");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("FAIL json_string_unescape_utf8");
        $finish;
    end

endmodule
